FILE: sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/bpdf_pkg.sv
`default_nettype none

package bpdf_pkg;

    localparam int unsigned MAX_BYTE_WIDTH_DEF = 128;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned FILTER_W   = 4;
    localparam int unsigned S_TDATA_W  = 6 * BYTE_W;
    localparam int unsigned S_TUSER_W  = FILTER_W + 1;
    localparam int unsigned M_TDATA_W  = 2 * BYTE_W;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_DATA_W-1:0] BYTE_WIDTH_RST = 8'd80;

    // Bit of the row mode that inverts the reference (or the input, for none and prefix).
    localparam int unsigned FLT_INV_BIT = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BYTE_WIDTH    = 1'b0,
        CFG_INVERT_STORED = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        FLT_NONE    = 3'd0,
        FLT_PREFIX  = 3'd1,
        FLT_ABOVE   = 3'd2,
        FLT_TILE    = 3'd3,
        FLT_PLANE_A = 3'd4,
        FLT_PLANE_B = 3'd5,
        FLT_PLANE_C = 3'd6,
        FLT_MASK    = 3'd7
    } filter_sel_t;

    typedef logic [BYTE_W-1:0] byte_t;

    // One input item held between the input and result registers.
    typedef struct packed {
        byte_t                data;
        byte_t                tile;
        byte_t                plane_a;
        byte_t                plane_b;
        byte_t                plane_c;
        byte_t                mask;
        logic [FILTER_W-1:0]  filter;
        logic                 plane_start;
        logic                 first_row;
        logic                 last;
    } stage_t;

    // Running XOR from the MSB down: bit i is the XOR of bits 7..i.
    function automatic byte_t prefix_xor(input byte_t v);
        byte_t x;
        x = v;
        x = x ^ (x >> 1);
        x = x ^ (x >> 2);
        x = x ^ (x >> 4);
        return x;
    endfunction

endpackage

`default_nettype wire

FILE: sv/bpdf_ram.sv
`default_nettype none

module bpdf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic                                      rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/bitplane_row_defilter.sv
// Bit-plane row defilter.
// Input channel s_*: one filtered plane byte per item together with its row
// mode and the reference bytes (tile above, three earlier planes, mask).
// Result channel m_*: the plain byte and its stored form; m_tlast marks the
// last byte of a row. The config port sets the row width in bytes and
// whether stored bytes are inverted; write it only while the block is idle.
// An accepted item passes the input register and then the result register
// before it shows on m_*. One item per cycle unless m_* stalls. The row-above
// byte comes from a line store RAM with registered read, addressed when the
// item is accepted; a write-to-read bypass covers one-byte rows and plane
// restarts at the column just written.
// Reset: no item is accepted while aresetn is low; the pipeline empties,
// the column restarts at zero, the first row is assumed, the prefix carry is
// cleared, the width returns to 80 and stored inversion is off. The line
// store is not cleared and must be written by a row before it is read.
// Stall: when m_tready is low the result register holds and one more item
// can wait behind it; s_tready drops only when both are full.
`default_nettype none

module bitplane_row_defilter #(
    parameter int unsigned MAX_BYTE_WIDTH = bpdf_pkg::MAX_BYTE_WIDTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                cfg_wr_en,
    input  wire logic [bpdf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [bpdf_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // packed_byte, tile_above_byte, plane_ref_a, plane_ref_b, plane_ref_c, mask_ref
    input  wire logic [bpdf_pkg::S_TDATA_W-1:0]      s_tdata,
    // row_filter, plane_start
    input  wire logic [bpdf_pkg::S_TUSER_W-1:0]      s_tuser,

    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // plain_byte, stored_byte
    output logic      [bpdf_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                     m_tlast
);

    import bpdf_pkg::*;

    localparam int unsigned CW = (MAX_BYTE_WIDTH > 1) ? $clog2(MAX_BYTE_WIDTH) : 1;
    localparam int unsigned LW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;

    // Control state
    logic                  s2_valid_reg, s2_valid_next;
    logic                  m_valid_reg, m_valid_next;
    logic [CW-1:0]         col_cnt_reg, col_cnt_next;
    logic                  first_row_reg, first_row_next;
    logic                  carry_reg, carry_next;
    logic [CFG_DATA_W-1:0] byte_width_reg, byte_width_next;
    logic                  invert_stored_reg, invert_stored_next;

    // Payload
    stage_t                s2_reg, s2_next;
    logic [CW-1:0]         s2_col_reg, s2_col_next;
    logic                  byp_hit_reg, byp_hit_next;
    byte_t                 byp_data_reg, byp_data_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;
    logic                  m_last_reg, m_last_next;

    logic                  accept;
    logic                  advance;
    logic                  plane_start_in;
    logic [CW-1:0]         col_cur;
    logic                  first_cur;
    logic [LW-1:0]         bw_ext;
    logic [LW-1:0]         eff_width;
    logic [LW-1:0]         col_inc;
    logic                  last_cur;

    byte_t                 above_rd;
    byte_t                 above_ref;
    byte_t                 inv_mask;
    logic                  carry_in;
    byte_t                 plain;
    byte_t                 stored;
    filter_sel_t           sel;

    assign plane_start_in = s_tuser[FILTER_W];

    assign advance  = s2_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = aresetn && (!s2_valid_reg || advance);
    assign accept   = s_tvalid && s_tready;

    // Column and row position of the arriving item
    always_comb begin
        col_cur   = plane_start_in ? '0 : col_cnt_reg;
        first_cur = plane_start_in | first_row_reg;
        bw_ext    = LW'(byte_width_reg);
        if (bw_ext == '0) begin
            eff_width = LW'(1);
        end else if (bw_ext > LW'(MAX_BYTE_WIDTH)) begin
            eff_width = LW'(MAX_BYTE_WIDTH);
        end else begin
            eff_width = bw_ext;
        end
        col_inc  = LW'(col_cur) + LW'(1);
        last_cur = (col_inc >= eff_width);
    end

    bpdf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_BYTE_WIDTH)
    ) u_line_store (
        .clk     (aclk),
        .wr_en   (advance),
        .wr_addr (s2_col_reg),
        .wr_data (plain),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (above_rd)
    );

    // Defilter the held item
    always_comb begin
        sel       = filter_sel_t'(s2_reg.filter[2:0]);
        inv_mask  = s2_reg.filter[FLT_INV_BIT] ? '1 : '0;
        carry_in  = s2_reg.plane_start ? 1'b0 : carry_reg;
        above_ref = s2_reg.first_row ? '0 : (byp_hit_reg ? byp_data_reg : above_rd);
        case (sel)
            FLT_NONE:    plain = s2_reg.data ^ inv_mask;
            FLT_PREFIX:  plain = prefix_xor(s2_reg.data ^ inv_mask ^ {carry_in, 7'b0});
            FLT_ABOVE:   plain = s2_reg.data ^ above_ref ^ inv_mask;
            FLT_TILE:    plain = s2_reg.data ^ s2_reg.tile ^ inv_mask;
            FLT_PLANE_A: plain = s2_reg.data ^ s2_reg.plane_a ^ inv_mask;
            FLT_PLANE_B: plain = s2_reg.data ^ s2_reg.plane_b ^ inv_mask;
            FLT_PLANE_C: plain = s2_reg.data ^ s2_reg.plane_c ^ inv_mask;
            FLT_MASK:    plain = s2_reg.data ^ s2_reg.mask ^ inv_mask;
            default:     plain = s2_reg.data ^ inv_mask;
        endcase
        stored = invert_stored_reg ? ~plain : plain;
    end

    always_comb begin
        s2_valid_next      = s2_valid_reg;
        m_valid_next       = m_valid_reg;
        col_cnt_next       = col_cnt_reg;
        first_row_next     = first_row_reg;
        carry_next         = carry_reg;
        byte_width_next    = byte_width_reg;
        invert_stored_next = invert_stored_reg;
        s2_next            = s2_reg;
        s2_col_next        = s2_col_reg;
        byp_hit_next       = byp_hit_reg;
        byp_data_next      = byp_data_reg;
        m_data_next        = m_data_reg;
        m_last_next        = m_last_reg;

        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                CFG_BYTE_WIDTH:    byte_width_next    = cfg_wdata;
                CFG_INVERT_STORED: invert_stored_next = cfg_wdata[0];
                default:           byte_width_next    = byte_width_reg;
            endcase
        end

        // Result register: load on advance, drain on take
        if (advance) begin
            m_valid_next = 1'b1;
            m_data_next  = {stored, plain};
            m_last_next  = s2_reg.last;
            if (s2_reg.last) begin
                carry_next = 1'b0;
            end else if (sel == FLT_PREFIX) begin
                carry_next = plain[0];
            end else begin
                carry_next = carry_in;
            end
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            s2_valid_next           = 1'b1;
            s2_next.data            = s_tdata[0*BYTE_W +: BYTE_W];
            s2_next.tile            = s_tdata[1*BYTE_W +: BYTE_W];
            s2_next.plane_a         = s_tdata[2*BYTE_W +: BYTE_W];
            s2_next.plane_b         = s_tdata[3*BYTE_W +: BYTE_W];
            s2_next.plane_c         = s_tdata[4*BYTE_W +: BYTE_W];
            s2_next.mask            = s_tdata[5*BYTE_W +: BYTE_W];
            s2_next.filter          = s_tuser[FILTER_W-1:0];
            s2_next.plane_start     = plane_start_in;
            s2_next.first_row       = first_cur;
            s2_next.last            = last_cur;
            s2_col_next             = col_cur;
            // The item leaving now writes the line store at the same edge
            byp_hit_next            = advance && (s2_col_reg == col_cur);
            byp_data_next           = plain;
            col_cnt_next            = last_cur ? '0 : col_inc[CW-1:0];
            first_row_next          = last_cur ? 1'b0 : first_cur;
        end else if (advance) begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            col_cnt_reg       <= '0;
            first_row_reg     <= 1'b1;
            carry_reg         <= 1'b0;
            byte_width_reg    <= BYTE_WIDTH_RST;
            invert_stored_reg <= 1'b0;
        end else begin
            s2_valid_reg      <= s2_valid_next;
            m_valid_reg       <= m_valid_next;
            col_cnt_reg       <= col_cnt_next;
            first_row_reg     <= first_row_next;
            carry_reg         <= carry_next;
            byte_width_reg    <= byte_width_next;
            invert_stored_reg <= invert_stored_next;
        end
    end

    always_ff @(posedge aclk) begin
        s2_reg       <= s2_next;
        s2_col_reg   <= s2_col_next;
        byp_hit_reg  <= byp_hit_next;
        byp_data_reg <= byp_data_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

FILE: sv/bpdf_checker.sv
`default_nettype none
`include "assert_macros.svh"

module bpdf_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [bpdf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [bpdf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                                s_tvalid,
    input  wire logic                                s_tready,
    input  wire logic [bpdf_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic [bpdf_pkg::S_TUSER_W-1:0]      s_tuser,
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic [bpdf_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire logic                                m_tlast
);

    import bpdf_pkg::*;

    logic in_acc;
    logic cfg_seen;
    logic in_seen;

    assign in_acc   = s_tvalid && s_tready;
    // Keep every port in the checker's view
    assign cfg_seen = cfg_wr_en ^ (|cfg_addr) ^ (|cfg_wdata);
    assign in_seen  = (|s_tdata) ^ (|s_tuser) ^ cfg_seen;

    // A stalled result holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
                 m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // A new result must trace back to an item taken at the input
    `ASSERT_IMPLY(a_out_latency, aclk, aresetn, $rose(m_tvalid), $past(in_acc, 2))

    // An empty result register means the block can take an item
    `ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready || (in_seen && 1'b0))

endmodule

bind bitplane_row_defilter bpdf_checker u_bpdf_checker (.*);

`default_nettype wire
